FILE: rtl/tgs_pkg.sv
// ----------------------------------------------------------------------------
// tgs_pkg: shared types and constants of the topic gibbs token sampler
// modes, status codes, fixed-point limits and sequencer states
// ----------------------------------------------------------------------------
package tgs_pkg;

	localparam int unsigned COUNT_W   = 9;
	localparam int unsigned PRIOR_W   = 17;
	localparam int unsigned WEIGHT_W  = 33;
	localparam int unsigned VALUE_W   = 16;
	localparam int unsigned TOPIC_W   = 5;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
	localparam logic [PRIOR_W-1:0] PRIOR_MAX = 17'h1FFFF;

	typedef enum logic [2:0] {
		MODE_LOAD_ALPHA = 3'd0,
		MODE_LOAD_PHI   = 3'd1,
		MODE_CLEAR_DOC  = 3'd2,
		MODE_INIT_TOKEN = 3'd3,
		MODE_SAMPLE     = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_SAMPLED = 2'd1,
		STATUS_ZERO    = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_TOPICS_G0 = 1'b0,
		REG_TOPICS_G1 = 1'b1
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TOKRD,
		ST_TOKWAIT,
		ST_SUM_ADDR,
		ST_SUM_WAIT,
		ST_SUM_MUL,
		ST_SUM_ACC,
		ST_THRESH,
		ST_SCAN,
		ST_CNT_RD,
		ST_CNT_WAIT,
		ST_CNT_WR,
		ST_CLEAR,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/tgs_ram.sv
// ----------------------------------------------------------------------------
// tgs_ram: generic single-port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module tgs_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: rtl/topic_gibbs_token_sampler.sv
// ----------------------------------------------------------------------------
// topic_gibbs_token_sampler: collapsed gibbs resampling of one word token
// per-document topic counts, token assignments, alpha and phi tables
// ----------------------------------------------------------------------------
// One input beat is handled at a time and the block is not ready meanwhile.
// A document's counts are cleared one count row a cycle. A sample for n topics
// in use makes a weight pass, a threshold, a scan and two count updates, and
// stops after the threshold on a zero total weight: the weight pass reads
// alpha, phi and count for one topic at a time through single-port memories
// and a shared 17x16 multiplier, the threshold takes one product of the total
// and the random value, the scan walks the weight buffer a topic a cycle up to
// the picked topic, and the two count updates come one after the other. The
// result beat waits in an output register; the next input beat is taken only
// once it has gone. Counts reset to zero by a clearing pass over the whole
// count memory after reset, during which no input beat is taken; configuration
// is always taken.
// ----------------------------------------------------------------------------
module topic_gibbs_token_sampler #(
	parameter int unsigned TOPICS     = 32,
	parameter int unsigned GROUPS     = 2,
	parameter int unsigned DOCS       = 16,
	parameter int unsigned MAX_TOKENS = 256,
	parameter int unsigned VOCAB      = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        valid_in,
	output logic        ready_in,
	input  logic [2:0]  mode,
	input  logic [0:0]  group,
	input  logic [3:0]  doc,
	input  logic [7:0]  position,
	input  logic [9:0]  word,
	input  logic [4:0]  topic,
	input  logic [15:0] value,
	input  logic [15:0] random,
	// result channel
	output logic        valid_out,
	input  logic        ready_out,
	output logic [4:0]  sampled_topic,
	output logic [1:0]  status,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tgs_pkg::*;

	localparam int unsigned TW = (TOPICS > 1) ? $clog2(TOPICS) : 1;
	localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int unsigned DW = (DOCS > 1) ? $clog2(DOCS) : 1;
	localparam int unsigned PW = $clog2(MAX_TOKENS);
	localparam int unsigned VW = $clog2(VOCAB);
	localparam int unsigned NW = $clog2(TOPICS + 1);
	localparam int unsigned ALPHA_D = GROUPS * TOPICS;
	localparam int unsigned PHI_D   = GROUPS * TOPICS * VOCAB;
	localparam int unsigned CNT_D   = GROUPS * DOCS * TOPICS;
	localparam int unsigned TOK_D   = GROUPS * DOCS * MAX_TOKENS;
	localparam int unsigned AAW = $clog2(ALPHA_D);
	localparam int unsigned PAW = $clog2(PHI_D);
	localparam int unsigned CAW = $clog2(CNT_D);
	localparam int unsigned KAW = $clog2(TOK_D);
	localparam int unsigned TOTAL_W = WEIGHT_W + TW;

	// configuration registers
	logic [5:0] topics_g0_q, topics_g1_q;
	logic       cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topics_g0_q <= 6'd32;
			topics_g1_q <= 6'd32;
		end else if (cfg_wr) begin
			unique case (reg_t'(paddr[2]))
				REG_TOPICS_G0: topics_g0_q <= pwdata[5:0];
				REG_TOPICS_G1: topics_g1_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_t'(paddr[2]))
			REG_TOPICS_G0: prdata[5:0] = topics_g0_q;
			REG_TOPICS_G1: prdata[5:0] = topics_g1_q;
			default: ;
		endcase
	end

	// captured input beat
	logic [2:0]       mode_q;
	logic [GW-1:0]    g_q;
	logic [DW-1:0]    d_q;
	logic [PW-1:0]    p_q;
	logic [VW-1:0]    w_q;
	logic [TW-1:0]    t_q;
	logic [15:0]      val_q;
	logic [15:0]      rnd_q;
	logic [NW-1:0]    n_q;

	// sequencer
	state_t state_q, state_d;
	logic [CAW:0]       clr_q;
	logic               clr_busy;
	logic [TW:0]        k_q;
	logic [TW-1:0]      old_q, pick_q;
	logic [TOTAL_W-1:0] total_q, run_q, thresh_q;
	logic [PRIOR_W-1:0] prior_q;
	logic               phase_q;      // count update: 0 old topic, 1 new topic
	logic [4:0]         out_topic_q;
	logic [1:0]         out_status_q;
	logic               out_valid_q;

	logic in_fire, out_fire;
	assign clr_busy  = (clr_q != CNT_D[CAW:0]);
	assign ready_in  = (state_q == ST_IDLE) && !clr_busy && !out_valid_q;
	assign in_fire   = valid_in && ready_in;
	assign valid_out = out_valid_q;
	assign out_fire  = out_valid_q && ready_out;
	assign sampled_topic = out_topic_q;
	assign status    = out_status_q;

	// index arithmetic
	logic [TW-1:0] k_idx;
	assign k_idx = k_q[TW-1:0];
	logic [CAW-1:0] cbase;
	assign cbase = CAW'((32'(g_q) * DOCS + 32'(d_q)) * TOPICS);

	// memories
	logic           a_we, p_we, c_we, t_we;
	logic [AAW-1:0] a_addr;
	logic [PAW-1:0] p_addr;
	logic [CAW-1:0] c_addr;
	logic [KAW-1:0] t_addr;
	logic [15:0]    a_rd, p_rd;
	logic [COUNT_W-1:0] c_rd, c_wd;
	logic [TOPIC_W-1:0] t_rd, t_wd;

	// weight buffer, one write and one read per cycle
	logic               wb_we;
	logic [TW-1:0]      wb_addr;
	logic [WEIGHT_W-1:0] wb_rd;

	// shared multiplier: prior times phi, written into the weight buffer
	logic [WEIGHT_W-1:0] weight_mul;
	assign weight_mul = WEIGHT_W'(prior_q) * WEIGHT_W'(p_rd);

	// the scan reads one entry ahead so the data lines up with k
	assign wb_addr = (state_q == ST_SCAN) ? k_idx + TW'(1) : k_idx;

	tgs_ram #(.WIDTH(16), .DEPTH(ALPHA_D)) u_alpha (
		.clk(clk), .we(a_we), .addr(a_addr), .wdata(val_q), .rdata(a_rd));
	tgs_ram #(.WIDTH(16), .DEPTH(PHI_D)) u_phi (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(val_q), .rdata(p_rd));
	tgs_ram #(.WIDTH(COUNT_W), .DEPTH(CNT_D)) u_count (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));
	tgs_ram #(.WIDTH(TOPIC_W), .DEPTH(TOK_D)) u_token (
		.clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));
	tgs_ram #(.WIDTH(WEIGHT_W), .DEPTH(TOPICS)) u_weight (
		.clk(clk), .we(wb_we), .addr(wb_addr), .wdata(weight_mul), .rdata(wb_rd));

	// the topic whose table rows are touched
	logic [TW-1:0] sel_topic;
	always_comb begin
		priority if (state_q == ST_CNT_RD || state_q == ST_CNT_WAIT ||
		             state_q == ST_CNT_WR) begin
			sel_topic = (mode_q == MODE_INIT_TOKEN) ? t_q :
			            (phase_q ? pick_q : old_q);
		end else if (mode_q == MODE_LOAD_ALPHA || mode_q == MODE_LOAD_PHI) begin
			sel_topic = t_q;
		end else begin
			sel_topic = k_idx;
		end
	end

	assign a_addr = AAW'(32'(g_q) * TOPICS + 32'(sel_topic));
	assign p_addr = PAW'((32'(g_q) * TOPICS + 32'(sel_topic)) * VOCAB + 32'(w_q));
	assign t_addr = KAW'((32'(g_q) * DOCS + 32'(d_q)) * MAX_TOKENS + 32'(p_q));
	assign c_addr = clr_busy ? clr_q[CAW-1:0] : (cbase + CAW'(sel_topic));

	// count after the old token leaves (weight pass)
	logic [COUNT_W-1:0] cnt_eff;
	logic [PRIOR_W:0]   prior_sum;
	assign cnt_eff   = (k_idx == old_q && c_rd != '0) ? c_rd - 1'b1 : c_rd;
	assign prior_sum = (PRIOR_W+1)'(a_rd) + {1'b0, cnt_eff, 8'd0};

	// the next count written in the update step
	always_comb begin
		if (mode_q == MODE_SAMPLE && !phase_q) begin
			c_wd = (c_rd != '0) ? c_rd - 1'b1 : c_rd;
		end else begin
			c_wd = (c_rd != COUNT_MAX) ? c_rd + 1'b1 : c_rd;
		end
		if (clr_busy || state_q == ST_CLEAR) begin
			c_wd = '0;
		end
	end
	assign t_wd = TOPIC_W'((mode_q == MODE_INIT_TOKEN) ? t_q : pick_q);

	logic [TOTAL_W+15:0] thresh_prod;
	assign thresh_prod = (TOTAL_W+16)'(total_q) * (TOTAL_W+16)'(rnd_q);
	logic [TOTAL_W-1:0] run_next;
	assign run_next = run_q + TOTAL_W'(wb_rd);

	always_comb begin
		state_d = state_q;
		a_we = 1'b0;
		p_we = 1'b0;
		c_we = clr_busy;
		t_we = 1'b0;
		wb_we = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (mode)
						MODE_LOAD_ALPHA, MODE_LOAD_PHI: state_d = ST_TOKRD;
						MODE_CLEAR_DOC:  state_d = ST_CLEAR;
						MODE_INIT_TOKEN: state_d = ST_CNT_RD;
						MODE_SAMPLE:     state_d = ST_TOKRD;
						default:         state_d = ST_OUT;
					endcase
				end
			end
			ST_TOKRD: begin
				a_we = (mode_q == MODE_LOAD_ALPHA);
				p_we = (mode_q == MODE_LOAD_PHI);
				state_d = (mode_q == MODE_SAMPLE) ? ST_TOKWAIT : ST_OUT;
			end
			ST_TOKWAIT:  state_d = ST_SUM_ADDR;
			ST_SUM_ADDR: state_d = ST_SUM_WAIT;
			ST_SUM_WAIT: state_d = ST_SUM_MUL;
			ST_SUM_MUL:  state_d = ST_SUM_ACC;
			ST_SUM_ACC: begin
				wb_we = 1'b1;
				if (k_q + 1'b1 == (TW+1)'(n_q)) begin
					state_d = ST_THRESH;
				end else begin
					state_d = ST_SUM_ADDR;
				end
			end
			ST_THRESH: state_d = (total_q == '0) ? ST_OUT : ST_SCAN;
			ST_SCAN: begin
				if (k_q != '0 && (run_q > thresh_q ||
				                  k_q == (TW+1)'(n_q))) begin
					state_d = ST_CNT_RD;
				end
			end
			ST_CNT_RD:   state_d = ST_CNT_WAIT;
			ST_CNT_WAIT: state_d = ST_CNT_WR;
			ST_CNT_WR: begin
				c_we = 1'b1;
				t_we = (mode_q == MODE_INIT_TOKEN) || phase_q;
				if (mode_q == MODE_SAMPLE && !phase_q) begin
					state_d = ST_CNT_RD;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_CLEAR: begin
				c_we = 1'b1;
				if (k_q + 1'b1 == (TW+1)'(TOPICS)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_busy) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_OUT && !out_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q  <= mode;
			g_q     <= GW'(32'(group) % GROUPS);
			d_q     <= DW'(32'(doc) % DOCS);
			p_q     <= PW'(32'(position) % MAX_TOKENS);
			w_q     <= VW'(32'(word) % VOCAB);
			t_q     <= TW'(32'(topic) % TOPICS);
			val_q   <= value;
			rnd_q   <= random;
			k_q     <= '0;
			total_q <= '0;
			run_q   <= '0;
			phase_q <= 1'b0;
			out_topic_q  <= '0;
			out_status_q <= STATUS_DONE;
		end
		if (state_q == ST_TOKRD) begin
			n_q <= NW'(32'(g_q) == 0 ?
			      ((topics_g0_q == 0) ? 1 : (topics_g0_q > TOPICS ? TOPICS : topics_g0_q)) :
			      ((topics_g1_q == 0) ? 1 : (topics_g1_q > TOPICS ? TOPICS : topics_g1_q)));
		end
		if (state_q == ST_TOKWAIT) begin
			old_q <= TW'(32'(t_rd) % TOPICS);
		end
		if (state_q == ST_SUM_MUL) begin
			prior_q <= prior_sum[PRIOR_W] ? PRIOR_MAX : prior_sum[PRIOR_W-1:0];
		end
		if (state_q == ST_SUM_ACC) begin
			k_q <= (k_q + 1'b1 == (TW+1)'(n_q)) ? '0 : k_q + 1'b1;
			total_q <= total_q + TOTAL_W'(weight_mul);
		end
		if (state_q == ST_THRESH) begin
			thresh_q <= thresh_prod[TOTAL_W+15:16];
			if (total_q == '0) begin
				out_topic_q  <= TOPIC_W'(old_q);
				out_status_q <= STATUS_ZERO;
			end
		end
		if (state_q == ST_SCAN) begin
			if (k_q != '0 && (run_q > thresh_q || k_q == (TW+1)'(n_q))) begin
				pick_q <= TW'(k_q - 1'b1);
			end else begin
				run_q <= run_next;
				k_q   <= k_q + 1'b1;
			end
		end
		if (state_q == ST_CNT_WR) begin
			phase_q <= 1'b1;
			if (mode_q == MODE_SAMPLE) begin
				out_topic_q  <= TOPIC_W'(pick_q);
				out_status_q <= STATUS_SAMPLED;
			end
		end
		if (state_q == ST_CLEAR) begin
			k_q <= k_q + 1'b1;
		end
	end

	// assertions
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !ready_in)
		else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_out && !ready_out) |=> (valid_out && $stable(sampled_topic)))
		else $error("result dropped");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !ready_in)
		else $error("input during clearing pass");
endmodule
